>>> rtl/core/xps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xps_pkg
// Shared constants and types of the xoshiro256++ generator with splitmix64
// seeding.
// ----------------------------------------------------------------------------
package xps_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned FRAC_W  = 53;
  localparam int unsigned NUM_WRD = 4;
  localparam int unsigned IDX_W   = $clog2(NUM_WRD);

  // splitmix64 constants
  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;
  localparam int unsigned MIX_SH_1 = 30;
  localparam int unsigned MIX_SH_2 = 27;
  localparam int unsigned MIX_SH_3 = 31;

  // xoshiro256++ constants
  localparam int unsigned XO_ROT_OUT = 23;
  localparam int unsigned XO_SHL     = 17;
  localparam int unsigned XO_ROT_W3  = 45;

  // item kinds
  localparam logic MODE_RESEED = 1'b0;
  localparam logic MODE_DRAW   = 1'b1;

  typedef struct packed {
    logic             busy;
    logic             word_vld;
    logic [IDX_W-1:0] word_idx;
  } mix_stat_t;

endpackage

>>> rtl/core/xoshiro_prng_splitmix_seeded.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro_prng_splitmix_seeded
// xoshiro256++ generator whose four state words are loaded from a splitmix64
// sequence on a reseed item; a draw item gives one 64-bit output.
//
//   channel | signals                              | direction
//   in      | in_valid_i/in_ready_o, mode, seed    | item in
//   out     | out_valid_o/out_ready_i, raw, frac   | result out
//
// a draw item's result sits in the output register
// a reseed item runs 4 words x 9 steps of the shared 32x32
//   multiplier sequencer after it is accepted; it gives no result
// in_ready_o is low while the sequencer runs, or while a result is held
//   and out_ready_i is low
// reset clears the state words to zero and empties the output register
// ----------------------------------------------------------------------------
module xoshiro_prng_splitmix_seeded (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [xps_pkg::WORD_W-1:0]  seed_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [xps_pkg::WORD_W-1:0]  raw_value_o,
  output logic [xps_pkg::FRAC_W-1:0]  uniform_fraction_o
);
  import xps_pkg::*;

  logic [NUM_WRD-1:0][WORD_W-1:0] gw_q, gw_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] raw_q, raw_d;

  mix_stat_t         mix_stat;
  logic [WORD_W-1:0] mix_word;
  logic              in_acc;
  logic              draw_acc;
  logic              seed_acc;

  logic [WORD_W-1:0] sum03, outv;
  logic [WORD_W-1:0] t2, t3, t1, t0;

  assign in_ready_o = !mix_stat.busy && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign draw_acc   = in_acc && (mode_i == MODE_DRAW);
  assign seed_acc   = in_acc && (mode_i == MODE_RESEED);

  xps_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seed_acc),
    .seed_i  (seed_value_i),
    .stat_o  (mix_stat),
    .word_o  (mix_word)
  );

  // xoshiro256++ step
  assign sum03 = gw_q[0] + gw_q[3];
  assign outv  = ((sum03 << XO_ROT_OUT) | (sum03 >> (WORD_W - XO_ROT_OUT))) + gw_q[0];
  assign t2    = gw_q[2] ^ gw_q[0];
  assign t3    = gw_q[3] ^ gw_q[1];
  assign t1    = gw_q[1] ^ t2;
  assign t0    = gw_q[0] ^ t3;

  always_comb begin
    gw_d        = gw_q;
    raw_d       = raw_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (mix_stat.word_vld) begin
      gw_d[mix_stat.word_idx] = mix_word;
    end
    if (draw_acc) begin
      gw_d[0]     = t0;
      gw_d[1]     = t1;
      gw_d[2]     = t2 ^ (gw_q[1] << XO_SHL);
      gw_d[3]     = (t3 << XO_ROT_W3) | (t3 >> (WORD_W - XO_ROT_W3));
      raw_d       = outv;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gw_q        <= gw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
  end

  assign out_valid_o        = out_valid_q;
  assign raw_value_o        = raw_q;
  assign uniform_fraction_o = raw_q[WORD_W-1:WORD_W-FRAC_W];

endmodule

>>> rtl/core/xps_mul32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xps_mul32
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module xps_mul32 (
  input  logic                         clk_i,
  input  logic [xps_pkg::HALF_W-1:0]   a_i,
  input  logic [xps_pkg::HALF_W-1:0]   b_i,
  output logic [xps_pkg::WORD_W-1:0]   prod_o
);
  import xps_pkg::*;

  logic [WORD_W-1:0] prod_q;
  logic [WORD_W-1:0] prod_d;

  assign prod_d = WORD_W'(a_i) * WORD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/core/xps_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xps_mix
// splitmix64 sequencer: produces four state words from a seed, one after the
// other, with each 64-bit multiply done as three partial products on the
// shared 32 x 32 multiplier.
// ----------------------------------------------------------------------------
module xps_mix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [xps_pkg::WORD_W-1:0]  seed_i,
  output xps_pkg::mix_stat_t          stat_o,
  output logic [xps_pkg::WORD_W-1:0]  word_o
);
  import xps_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MIX  = 3'd1;
  localparam logic [2:0] PH_LL   = 3'd2;
  localparam logic [2:0] PH_LH   = 3'd3;
  localparam logic [2:0] PH_HL   = 3'd4;
  localparam logic [2:0] PH_FIN  = 3'd5;

  logic [2:0]        phase_q, phase_d;
  logic              selb_q, selb_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [WORD_W-1:0] ctr_q, ctr_d;
  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] acc_q, acc_d;

  logic [WORD_W-1:0] ctr_nxt;
  logic [WORD_W-1:0] kmul;
  logic [HALF_W-1:0] op_a, op_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] prod_hi;
  logic [WORD_W-1:0] fin;
  logic [WORD_W-1:0] word;

  xps_mul32 u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  assign kmul    = selb_q ? MIX_MUL_B : MIX_MUL_A;
  assign ctr_nxt = ctr_q + GOLDEN_GAMMA;
  // cross products only reach the upper half of the low 64 bits
  assign prod_hi = {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  assign fin     = acc_q + prod_hi;
  assign word    = fin ^ (fin >> MIX_SH_3);

  always_comb begin
    case (phase_q)
      PH_LH: begin
        op_a = x_q[HALF_W-1:0];
        op_b = kmul[WORD_W-1:HALF_W];
      end
      PH_HL: begin
        op_a = x_q[WORD_W-1:HALF_W];
        op_b = kmul[HALF_W-1:0];
      end
      default: begin
        op_a = x_q[HALF_W-1:0];
        op_b = kmul[HALF_W-1:0];
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    selb_d  = selb_q;
    idx_d   = idx_q;
    ctr_d   = ctr_q;
    x_d     = x_q;
    acc_d   = acc_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          ctr_d   = seed_i;
          idx_d   = '0;
          phase_d = PH_MIX;
        end
      end
      PH_MIX: begin
        ctr_d   = ctr_nxt;
        x_d     = ctr_nxt ^ (ctr_nxt >> MIX_SH_1);
        selb_d  = 1'b0;
        phase_d = PH_LL;
      end
      PH_LL: begin
        phase_d = PH_LH;
      end
      PH_LH: begin
        acc_d   = prod;
        phase_d = PH_HL;
      end
      PH_HL: begin
        acc_d   = acc_q + prod_hi;
        phase_d = PH_FIN;
      end
      PH_FIN: begin
        if (!selb_q) begin
          x_d     = fin ^ (fin >> MIX_SH_2);
          selb_d  = 1'b1;
          phase_d = PH_LL;
        end else begin
          idx_d   = idx_q + 1'b1;
          phase_d = (idx_q == IDX_W'(NUM_WRD - 1)) ? PH_IDLE : PH_MIX;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      selb_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      selb_q  <= selb_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q <= ctr_d;
    x_q   <= x_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy     = (phase_q != PH_IDLE);
  assign stat_o.word_vld = (phase_q == PH_FIN) && selb_q;
  assign stat_o.word_idx = idx_q;
  assign word_o          = word;

endmodule

>>> rtl/core/xps_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xps_chk
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module xps_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [xps_pkg::WORD_W-1:0]  raw_value_o,
  input  logic [xps_pkg::FRAC_W-1:0]  uniform_fraction_o
);
  import xps_pkg::*;

  logic draw_acc;
  logic seed_acc;

  assign draw_acc = in_valid_i && in_ready_o && (mode_i == MODE_DRAW);
  assign seed_acc = in_valid_i && in_ready_o && (mode_i == MODE_RESEED);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(raw_value_o))
    else $error("result changed while stalled");

  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_acc |=> out_valid_o)
    else $error("draw item gave no result");

  a_seed_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_acc |=> !out_valid_o && !in_ready_o)
    else $error("reseed item gave a result or did not stall input");

  a_frac_top_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> uniform_fraction_o == raw_value_o[WORD_W-1:WORD_W-FRAC_W])
    else $error("fraction does not match raw value");

endmodule

bind xoshiro_prng_splitmix_seeded xps_chk u_xps_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .mode_i             (mode_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .raw_value_o        (raw_value_o),
  .uniform_fraction_o (uniform_fraction_o)
);

>>> dv/tb_xoshiro_prng_splitmix_seeded.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xoshiro_prng_splitmix_seeded
// Self-checking bench for the xoshiro256++ generator with splitmix64 seeding.
// Reseed and draw items go in over a valid/ready channel and are mirrored in
// a bench-side generator model; each draw result coming out is compared
// field by field with the oldest predicted draw. Directed tests cover the
// unseeded zero state, seed extremes and reseed overwrite, then a long
// output stall and a random mix of seeds and draws with random idling.
// ----------------------------------------------------------------------------
module tb_xoshiro_prng_splitmix_seeded;
  import xps_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS = 1650;

  typedef struct {
    logic [WORD_W-1:0] raw;
    logic [FRAC_W-1:0] frac;
  } draw_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              mode_i = MODE_DRAW;
  logic [WORD_W-1:0] seed_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] raw_value_o;
  logic [FRAC_W-1:0] uniform_fraction_o;

  logic [WORD_W-1:0] prng_state [NUM_WRD];
  draw_result_t      draw_results_q [$];
  int unsigned       mismatch_count = 0;
  int unsigned       idle_count = 0;
  bit                no_idle = 1'b0;
  bit                hold_off_req = 1'b0;

  xoshiro_prng_splitmix_seeded u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .seed_value_i       (seed_value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .raw_value_o        (raw_value_o),
    .uniform_fraction_o (uniform_fraction_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] v, int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] z);
    z = (z ^ (z >> MIX_SH_1)) * MIX_MUL_A;
    z = (z ^ (z >> MIX_SH_2)) * MIX_MUL_B;
    return z ^ (z >> MIX_SH_3);
  endfunction

  function automatic void load_seed(logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] ctr;
    ctr = seed;
    for (int i = 0; i < NUM_WRD; i++) begin
      ctr += GOLDEN_GAMMA;
      prng_state[i] = mix_word(ctr);
    end
  endfunction

  function automatic logic [WORD_W-1:0] advance_state();
    logic [WORD_W-1:0] outv;
    logic [WORD_W-1:0] shl;
    outv = rotl64(prng_state[0] + prng_state[3], XO_ROT_OUT) + prng_state[0];
    shl = prng_state[1] << XO_SHL;
    prng_state[2] ^= prng_state[0];
    prng_state[3] ^= prng_state[1];
    prng_state[1] ^= prng_state[2];
    prng_state[0] ^= prng_state[3];
    prng_state[2] ^= shl;
    prng_state[3] = rotl64(prng_state[3], XO_ROT_W3);
    return outv;
  endfunction

  // ---------------------------------------------------------------- sender

  // valid is only lowered when a gap follows, so back-to-back items keep it high
  task automatic send_item(input logic mode, input logic [WORD_W-1:0] seed);
    int unsigned gap;
    logic [WORD_W-1:0] raw;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    seed_value_i <= seed;
    do @(posedge clk_i); while (!in_ready_o);
    if (mode == MODE_DRAW) begin
      raw = advance_state();
      draw_results_q.push_back('{raw, raw[WORD_W-1 -: FRAC_W]});
    end else begin
      load_seed(seed);
    end
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------- receiver

  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (draw_results_q.size() == 0) begin
        report_mismatch("unrequested result raw_value", '0, raw_value_o);
      end else begin
        want = draw_results_q.pop_front();
        if (raw_value_o !== want.raw)
          report_mismatch("raw_value", want.raw, raw_value_o);
        if (uniform_fraction_o !== want.frac)
          report_mismatch("uniform_fraction", WORD_W'(want.frac), WORD_W'(uniform_fraction_o));
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // all-zero state is a fixed point, the seed on a draw is ignored
  task automatic test_unseeded_draws();
    send_item(MODE_DRAW, '0);
    send_item(MODE_DRAW, '1);
    send_item(MODE_DRAW, rand_word());
  endtask

  task automatic test_seed_extremes();
    send_item(MODE_RESEED, '0);
    send_item(MODE_DRAW, '1);
    send_item(MODE_DRAW, '0);
    send_item(MODE_RESEED, '1);
    send_item(MODE_DRAW, '0);
    // first counter value wraps to zero
    send_item(MODE_RESEED, -GOLDEN_GAMMA);
    send_item(MODE_DRAW, '0);
    send_item(MODE_RESEED, {1'b1, {(WORD_W-1){1'b0}}});
    send_item(MODE_DRAW, '1);
  endtask

  // reseed replaces the whole state, so a repeated seed repeats the draws
  task automatic test_reseed_overwrite();
    logic [WORD_W-1:0] seed;
    seed = rand_word();
    send_item(MODE_RESEED, seed);
    send_item(MODE_DRAW, rand_word());
    send_item(MODE_DRAW, rand_word());
    send_item(MODE_RESEED, rand_word());
    send_item(MODE_RESEED, seed);
    send_item(MODE_DRAW, rand_word());
    send_item(MODE_DRAW, rand_word());
  endtask

  task automatic test_output_stall();
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_item(MODE_DRAW, rand_word());
  endtask

  task automatic test_random_traffic();
    logic [WORD_W-1:0] seed;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 7))
          0:       seed = '0;
          1:       seed = '1;
          default: seed = rand_word();
        endcase
        send_item(MODE_RESEED, seed);
      end else begin
        send_item(MODE_DRAW, rand_word());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_WRD; i++)
      prng_state[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unseeded_draws();
    test_seed_extremes();
    test_reseed_overwrite();
    test_output_stall();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (draw_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && draw_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
